// ===== sv/dsts_pkg.sv =====
// dsts_pkg: types, codes and constants of the disk sector transfer sequencer
// no dependencies; imported by dsts_cfg_if and by every module of the block
`default_nettype none

package dsts_pkg;

    // defaults for the top level parameters
    localparam int SECTORS_PER_BLOCK_DEF = 85;
    localparam int C1_ERR_SLOTS_DEF      = 4;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_CMD_TYPE_INIT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANSFER_MODE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SECTOR_SIZE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DRAM_BASE_BLOCK0 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DRAM_BASE_BLOCK1 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_C2_ADDR_BLOCK0   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_C2_ADDR_BLOCK1   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_BM_CTL_SHADOW    = 3'd7;

    // request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_EVENT = 1'b1;

    // command types
    localparam logic [1:0] CMD_READ    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_DONE    = 2'd2;
    localparam logic [1:0] CMD_INVALID = 2'd3;

    // transfer modes with special handling
    localparam logic [1:0] MODE_TWO_BLOCK = 2'd2;
    localparam logic [1:0] MODE_SPECIAL   = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RETRY   = 3'd1;
    localparam logic [2:0] ST_ECC     = 3'd2;
    localparam logic [2:0] ST_COUNT   = 3'd3;
    localparam logic [2:0] ST_BUS     = 3'd4;
    localparam logic [2:0] ST_BAD_CMD = 3'd5;

    // buffer manager actions
    localparam logic [1:0] BM_NONE  = 2'd0;
    localparam logic [1:0] BM_ACK   = 2'd1;
    localparam logic [1:0] BM_RESET = 2'd2;

    // drive status bits
    localparam logic [31:0] AS_ACK    = 32'h0200_0000;
    localparam logic [31:0] AS_DRVERR = 32'h0800_0000;
    localparam logic [31:0] AS_C2     = 32'h1000_0000;
    localparam logic [31:0] AS_DREQ   = 32'h4000_0000;

    // buffer manager C1 error bits
    localparam logic [31:0] BM_C1A = 32'h0020_0000;
    localparam logic [31:0] BM_C1B = 32'h0040_0000;
    localparam logic [31:0] BM_C1C = 32'h0200_0000;

    // slack between c1 error count and sector number in special mode
    localparam logic [7:0] C1_SECTOR_SLACK = 8'h11;

    typedef struct packed {
        logic [1:0]  cmd_type_init;
        logic [1:0]  transfer_mode;
        logic [15:0] sector_size;
        logic [31:0] dram_base_block0;
        logic [31:0] dram_base_block1;
        logic [31:0] c2_addr_block0;
        logic [31:0] c2_addr_block1;
    } cfg_regs_t;

    typedef struct packed {
        logic        req_type;
        logic        pi_error;
        logic [31:0] asic_status;
        logic [31:0] bm_status;
        logic        c2_nonzero;
        logic [7:0]  start_sector;
        logic        start_block;
    } item_t;

    typedef struct packed {
        logic [1:0]       cmd_type;
        logic [7:0]       sector_num;
        logic             block_num;
        logic [1:0][31:0] dram_ptr;
        logic [1:0][7:0]  c1_err_count;
    } state_t;

    typedef struct packed {
        logic        status_valid;
        logic [2:0]  status_code;
        logic        status_block;
        logic        handled;
        logic        dma_start;
        logic        dma_to_device;
        logic        dma_c2_buffer;
        logic [31:0] dma_dram_addr;
        logic [17:0] dma_length;
        logic [1:0]  bm_action;
        logic        post_event;
        logic        bus_clear_mask;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/dsts_if.sv =====
// dsts_if: valid/ready channels of the sequencer (event items, results, config writes)
// depends on dsts_pkg for the configuration port widths
`default_nettype none

interface dsts_item_if;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic              pi_error;
    logic [31:0]       asic_status;
    logic [31:0]       bm_status;
    logic              c2_nonzero;
    logic signed [7:0] start_sector;
    logic              start_block;

    modport source (
        output valid, req_type, pi_error, asic_status, bm_status, c2_nonzero,
               start_sector, start_block,
        input  ready
    );
    modport sink (
        input  valid, req_type, pi_error, asic_status, bm_status, c2_nonzero,
               start_sector, start_block,
        output ready
    );
endinterface

interface dsts_result_if;
    logic        valid;
    logic        ready;
    logic        status_valid;
    logic [2:0]  status_code;
    logic        status_block;
    logic        handled;
    logic        dma_start;
    logic        dma_to_device;
    logic        dma_c2_buffer;
    logic [31:0] dma_dram_addr;
    logic [17:0] dma_length;
    logic [1:0]  bm_action;
    logic        post_event;
    logic        bus_clear_mask;

    modport source (
        output valid, status_valid, status_code, status_block, handled, dma_start,
               dma_to_device, dma_c2_buffer, dma_dram_addr, dma_length, bm_action,
               post_event, bus_clear_mask,
        input  ready
    );
    modport sink (
        input  valid, status_valid, status_code, status_block, handled, dma_start,
               dma_to_device, dma_c2_buffer, dma_dram_addr, dma_length, bm_action,
               post_event, bus_clear_mask,
        output ready
    );
endinterface

interface dsts_cfg_if import dsts_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/dsts_cfg_regs.sv =====
// dsts_cfg_regs: configuration register file of the sequencer
// depends on dsts_pkg and on dsts_cfg_if
`default_nettype none

module dsts_cfg_regs import dsts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dsts_cfg_if.sink   cfg,
    output cfg_regs_t  regs
);

    cfg_regs_t regs_reg;

    // writes are taken in any cycle
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_CMD_TYPE_INIT:    regs_reg.cmd_type_init    <= cfg.data[1:0];
                REG_TRANSFER_MODE:    regs_reg.transfer_mode    <= cfg.data[1:0];
                REG_SECTOR_SIZE:      regs_reg.sector_size      <= cfg.data[15:0];
                REG_DRAM_BASE_BLOCK0: regs_reg.dram_base_block0 <= cfg.data;
                REG_DRAM_BASE_BLOCK1: regs_reg.dram_base_block1 <= cfg.data;
                REG_C2_ADDR_BLOCK0:   regs_reg.c2_addr_block0   <= cfg.data;
                REG_C2_ADDR_BLOCK1:   regs_reg.c2_addr_block1   <= cfg.data;
                // shadow control word has no effect on any result
                REG_BM_CTL_SHADOW:    ;
                default:              ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/dsts_event_logic.sv =====
// dsts_event_logic: decision logic for one item, next transfer state and result
// depends on dsts_pkg; purely combinational, placed between the item and result registers
`default_nettype none

module dsts_event_logic import dsts_pkg::*;
#(
    parameter int SECTORS_PER_BLOCK = SECTORS_PER_BLOCK_DEF,
    parameter int C1_ERR_SLOTS      = C1_ERR_SLOTS_DEF
)
(
    input  state_t    state,
    input  cfg_regs_t regs,
    input  item_t     item,
    output state_t    state_next,
    output result_t   res
);

    localparam logic signed [9:0] SPB    = 10'(SECTORS_PER_BLOCK);
    localparam logic signed [9:0] SPB_M2 = 10'(SECTORS_PER_BLOCK - 2);
    localparam logic signed [9:0] SPB_P2 = 10'(SECTORS_PER_BLOCK + 2);
    localparam logic signed [9:0] SPB_X2 = 10'(2 * SECTORS_PER_BLOCK);
    localparam logic signed [9:0] SPB_X3 = 10'(3 * SECTORS_PER_BLOCK);
    localparam logic [7:0]        SLOTS  = 8'(C1_ERR_SLOTS);

    // error exit: reset pulse, post and bus clear
    function automatic result_t fail_res(input logic [2:0] code, input logic blk);
        result_t r;
        r                = '0;
        r.handled        = 1'b1;
        r.status_valid   = 1'b1;
        r.status_code    = code;
        r.status_block   = blk;
        r.bm_action      = BM_RESET;
        r.post_event     = 1'b1;
        r.bus_clear_mask = 1'b1;
        return r;
    endfunction

    logic              blk;
    logic [7:0]        cnt;
    logic [31:0]       ptr;
    logic [31:0]       ptr_step;
    logic [7:0]        sector_inc;
    logic signed [9:0] sect;
    logic signed [9:0] sect_inc;
    logic signed [9:0] s_new;
    logic signed [9:0] cnt_slack;
    logic signed [9:0] mode_target;
    logic              dreq;
    logic              c2_req;
    logic              c1err;
    logic              special;
    logic              c1_over;
    logic              post0;

    assign blk        = state.block_num;
    assign cnt        = state.c1_err_count[blk];
    assign ptr        = state.dram_ptr[blk];
    assign ptr_step   = ptr + {16'b0, regs.sector_size};
    assign sector_inc = state.sector_num + 8'd1;
    assign sect       = {{2{state.sector_num[7]}}, state.sector_num};
    assign sect_inc   = sect + 10'sd1;
    assign s_new      = {{2{sector_inc[7]}}, sector_inc};
    assign cnt_slack  = signed'({2'b00, cnt} + {2'b00, C1_SECTOR_SLACK});

    assign dreq    = (item.asic_status & AS_DREQ) != '0;
    assign c2_req  = (item.asic_status & AS_C2) != '0;
    assign c1err   = (((item.bm_status & BM_C1A) != '0) && ((item.bm_status & BM_C1B) != '0))
                     || ((item.bm_status & BM_C1C) != '0);
    assign special = regs.transfer_mode == MODE_SPECIAL;
    assign c1_over = (cnt >= SLOTS) && (!special || (sect >= SPB_M2));
    // start of block one in two-block mode closes block zero
    assign post0   = (sect == -10'sd1) && (regs.transfer_mode == MODE_TWO_BLOCK) && blk;

    always_comb
    begin
        case (regs.transfer_mode)
            2'd0:    mode_target = '0;
            2'd1:    mode_target = SPB;
            2'd2:    mode_target = SPB_X2;
            default: mode_target = SPB_X3;
        endcase
    end

    always_comb
    begin
        state_next  = state;
        res         = '0;
        res.handled = 1'b1;

        if (item.req_type == REQ_START)
        begin
            state_next.cmd_type     = regs.cmd_type_init;
            state_next.sector_num   = item.start_sector;
            state_next.block_num    = item.start_block;
            state_next.dram_ptr[0]  = regs.dram_base_block0;
            state_next.dram_ptr[1]  = regs.dram_base_block1;
            state_next.c1_err_count = '0;
            res.handled             = 1'b0;
        end
        else if (item.pi_error)
        begin
            res.status_valid = 1'b1;
            res.status_code  = ST_BUS;
            res.status_block = blk;
            res.post_event   = 1'b1;
        end
        else if ((item.asic_status & AS_ACK) != '0)
        begin
            res.bm_action    = BM_ACK;
            res.status_valid = 1'b1;
            res.status_code  = ST_OK;
            res.status_block = blk;
            res.handled      = 1'b0;
        end
        else if (state.cmd_type == CMD_DONE)
        begin
            // nothing left to do
        end
        else if ((item.asic_status & AS_DRVERR) != '0)
        begin
            res.status_valid   = 1'b1;
            res.status_code    = ST_RETRY;
            res.status_block   = blk;
            res.post_event     = 1'b1;
            res.bus_clear_mask = 1'b1;
        end
        else if (state.cmd_type == CMD_WRITE)
        begin
            if (!dreq)
            begin
                if (sect_inc != mode_target)
                begin
                    res = fail_res(ST_COUNT, blk);
                end
                else
                begin
                    res.bus_clear_mask = 1'b1;
                    res.status_valid   = 1'b1;
                    res.status_code    = ST_OK;
                    res.status_block   = blk;
                    res.post_event     = 1'b1;
                end
            end
            else
            begin
                state_next.dram_ptr[blk] = ptr_step;
                state_next.sector_num    = sector_inc;
                res.dma_start            = 1'b1;
                res.dma_to_device        = 1'b1;
                res.dma_dram_addr        = ptr_step;
                res.dma_length           = {2'b00, regs.sector_size};
            end
        end
        else if (state.cmd_type == CMD_READ)
        begin
            if (special && (cnt_slack < sect))
            begin
                res = fail_res(ST_OK, blk);
            end
            else if (special && !dreq)
            begin
                res = fail_res(ST_ECC, blk);
            end
            else
            begin
                if (!special)
                begin
                    state_next.dram_ptr[blk] = ptr_step;
                end
                if (c1err && c1_over)
                begin
                    res = fail_res(ST_ECC, blk);
                end
                else
                begin
                    if (c1err)
                    begin
                        state_next.c1_err_count[blk] = cnt + 8'd1;
                    end
                    if (c2_req)
                    begin
                        if (sect != SPB_P2)
                        begin
                            res = fail_res(ST_COUNT, blk);
                        end
                        else
                        begin
                            if ((regs.transfer_mode == MODE_TWO_BLOCK) && !blk)
                            begin
                                // move on to block one, first sector comes next
                                state_next.block_num   = 1'b1;
                                state_next.sector_num  = 8'hFF;
                                state_next.dram_ptr[1] = state.dram_ptr[1]
                                                         - {16'b0, regs.sector_size};
                                res.status_code        = ST_RETRY;
                            end
                            else
                            begin
                                res.bus_clear_mask  = 1'b1;
                                state_next.cmd_type = CMD_DONE;
                                res.status_code     = ST_OK;
                            end
                            res.status_valid  = 1'b1;
                            res.status_block  = blk;
                            res.dma_start     = 1'b1;
                            res.dma_c2_buffer = 1'b1;
                            res.dma_dram_addr = blk ? regs.c2_addr_block1
                                                    : regs.c2_addr_block0;
                            res.dma_length    = {regs.sector_size, 2'b00};
                        end
                    end
                    else if (post0 && (state.c1_err_count[0] == '0) && item.c2_nonzero)
                    begin
                        res = fail_res(ST_ECC, 1'b0);
                    end
                    else
                    begin
                        state_next.sector_num = sector_inc;
                        if (post0)
                        begin
                            res.status_valid = 1'b1;
                            res.status_code  = ST_OK;
                            res.status_block = 1'b0;
                            res.post_event   = 1'b1;
                        end
                        if (dreq)
                        begin
                            if (s_new >= SPB)
                            begin
                                res = fail_res(ST_COUNT, blk);
                            end
                            else
                            begin
                                res.dma_start     = 1'b1;
                                res.dma_dram_addr = special ? ptr : ptr_step;
                                res.dma_length    = {2'b00, regs.sector_size};
                                res.status_valid  = 1'b1;
                                res.status_code   = ST_OK;
                                res.status_block  = blk;
                            end
                        end
                        else if (s_new < SPB)
                        begin
                            res = fail_res(ST_COUNT, blk);
                        end
                    end
                end
            end
        end
        else
        begin
            res = fail_res(ST_BAD_CMD, blk);
        end
    end

endmodule

`default_nettype wire

// ===== sv/disk_sector_transfer_sequencer.sv =====
// disk_sector_transfer_sequencer: top level, item and result registers, transfer state
// depends on dsts_pkg, dsts_if, dsts_cfg_regs and dsts_event_logic
//
// Sequences a disk sector transfer one interrupt event at a time. A start item
// (req_type 0) loads command, sector, block and both DRAM pointers from the
// configuration registers and the item; every event item (req_type 1) gives one
// result with any status code and the actions to take: sector or C2 DMA, buffer
// manager acknowledge or reset pulse, event posting and bus clear. Each item
// gives exactly one result. An accepted item is held in the item register; the
// decision logic then writes the transfer state and the result register once the
// result register is empty or being taken, and the result stays on the port until
// it is taken. The block takes one item every cycle while the result side keeps up.
// The sustained rate is set by the loop on the transfer state, which closes
// through the decision logic alone. When the result is stalled both registers
// hold, and item ready drops once the item register is full too. Configuration
// writes are taken in every cycle and must only arrive while the block is idle.
`default_nettype none

module disk_sector_transfer_sequencer import dsts_pkg::*;
#(
    parameter int SECTORS_PER_BLOCK = SECTORS_PER_BLOCK_DEF,
    parameter int C1_ERR_SLOTS      = C1_ERR_SLOTS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    dsts_item_if.sink    item,
    dsts_result_if.source result,
    dsts_cfg_if.sink     cfg
);

    cfg_regs_t regs;

    // item stage
    item_t   item_reg;
    logic    item_valid_reg;
    item_t   item_in;
    logic    item_take;

    // transfer state, updated when an item moves into the result register
    state_t  state_reg;
    state_t  state_next;

    // result stage
    result_t res_next;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;

    dsts_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    dsts_event_logic
    #(
        .SECTORS_PER_BLOCK (SECTORS_PER_BLOCK),
        .C1_ERR_SLOTS      (C1_ERR_SLOTS)
    )
    u_event_logic
    (
        .state      (state_reg),
        .regs       (regs),
        .item       (item_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    // result register frees up when empty or being taken
    assign advance    = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign item_take  = item.valid && item.ready;

    // pack the item fields
    assign item_in.req_type     = item.req_type;
    assign item_in.pi_error     = item.pi_error;
    assign item_in.asic_status  = item.asic_status;
    assign item_in.bm_status    = item.bm_status;
    assign item_in.c2_nonzero   = item.c2_nonzero;
    assign item_in.start_sector = item.start_sector;
    assign item_in.start_block  = item.start_block;

    // control flags of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // transfer state starts all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item_in;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // unpack the result fields
    assign result.valid          = res_valid_reg;
    assign result.status_valid   = res_reg.status_valid;
    assign result.status_code    = res_reg.status_code;
    assign result.status_block   = res_reg.status_block;
    assign result.handled        = res_reg.handled;
    assign result.dma_start      = res_reg.dma_start;
    assign result.dma_to_device  = res_reg.dma_to_device;
    assign result.dma_c2_buffer  = res_reg.dma_c2_buffer;
    assign result.dma_dram_addr  = res_reg.dma_dram_addr;
    assign result.dma_length     = res_reg.dma_length;
    assign result.bm_action      = res_reg.bm_action;
    assign result.post_event     = res_reg.post_event;
    assign result.bus_clear_mask = res_reg.bus_clear_mask;

endmodule

`default_nettype wire

// ===== sv/dsts_checker.sv =====
// dsts_checker: port-level assertions on the sequencer, with its bind
// depends on dsts_pkg and on disk_sector_transfer_sequencer
`default_nettype none

module dsts_checker import dsts_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        status_valid,
    input logic        handled,
    input logic        dma_start,
    input logic        dma_to_device,
    input logic        dma_c2_buffer,
    input logic [31:0] dma_dram_addr,
    input logic [17:0] dma_length,
    input logic [1:0]  bm_action,
    input logic        post_event,
    input logic        bus_clear_mask
);

    // stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status_valid) && $stable(bm_action)
            && $stable(dma_dram_addr) && $stable(dma_length) && $stable(handled))
        else $error("result changed while stalled");

    // unhandled means start item or acknowledge
    a_unhandled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !handled |->
            (bm_action == BM_ACK && status_valid && !dma_start)
            || (bm_action == BM_NONE && !status_valid && !dma_start && !post_event))
        else $error("unhandled result with unexpected actions");

    // error exit always posts and clears the bus
    a_error_exit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bm_action == BM_RESET |->
            post_event && bus_clear_mask && status_valid && !dma_start)
        else $error("reset pulse without full error exit");

    // idle dma fields are zero
    a_no_dma: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dma_start |->
            dma_dram_addr == '0 && dma_length == '0 && !dma_to_device && !dma_c2_buffer)
        else $error("dma fields set without dma start");

endmodule

bind disk_sector_transfer_sequencer dsts_checker u_dsts_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .status_valid   (result.status_valid),
    .handled        (result.handled),
    .dma_start      (result.dma_start),
    .dma_to_device  (result.dma_to_device),
    .dma_c2_buffer  (result.dma_c2_buffer),
    .dma_dram_addr  (result.dma_dram_addr),
    .dma_length     (result.dma_length),
    .bm_action      (result.bm_action),
    .post_event     (result.post_event),
    .bus_clear_mask (result.bus_clear_mask)
);

`default_nettype wire
